// File: rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request, result and internal operation types and codes shared by the
// double-ended queue front end, back end and checker.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int VALUE_W = 32;
    localparam int ADDR_W  = 6;
    localparam int LEN_W   = 7;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DUMP       = 3'd4
    } command_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_EMPTY = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        OP_NOTE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_DUMP  = 2'd3
    } op_kind_e;

    typedef struct packed {
        logic [2:0]                command;
        logic signed [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] data;
        logic                      last;
    } result_t;

    typedef struct packed {
        op_kind_e                  kind;
        status_e                   status;
        logic [ADDR_W-1:0]         addr;
        logic [LEN_W-1:0]          len;
        logic signed [VALUE_W-1:0] value;
    } op_t;

endpackage

// File: rtl/core/dq_fifo.sv
// ----------------------------------------------------------------------------
// Double-ended queue small FIFO
// Register-based first-in first-out buffer with 2**AW entries and a fill level.
// ----------------------------------------------------------------------------
module dq_fifo #(
    parameter int  AW     = 1,
    parameter type item_t = logic
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  item_t         wr_data,
    output logic          full,
    input  logic          rd_en,
    output item_t         rd_data,
    output logic          empty,
    output logic [AW:0]   level
);

    localparam int N = 1 << AW;

    item_t          store_reg [N];
    logic [AW-1:0]  wp_reg;
    logic [AW-1:0]  rp_reg;
    logic [AW:0]    cnt_reg;
    logic           do_wr;
    logic           do_rd;

    assign full    = (cnt_reg == (AW+1)'(N));
    assign empty   = (cnt_reg == '0);
    assign level   = cnt_reg;
    assign rd_data = store_reg[rp_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/dq_front.sv
// ----------------------------------------------------------------------------
// Double-ended queue front end
// Tracks front index and element count, classifies each request and turns it
// into a memory operation for the back end.
// ----------------------------------------------------------------------------
module dq_front #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  dq_pkg::request_t  request,
    output dq_pkg::op_t       op
);
    import dq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 2;

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             is_full;
    logic             is_empty;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sum_m1;
    logic [IDX_W-1:0] back_pos;
    logic [IDX_W-1:0] back_last;

    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign sum       = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign sum_m1    = sum - 1'b1;
    assign back_pos  = (sum >= SUM_W'(DEPTH)) ? IDX_W'(sum - SUM_W'(DEPTH))
                                              : sum[IDX_W-1:0];
    assign back_last = (sum_m1 >= SUM_W'(DEPTH)) ? IDX_W'(sum_m1 - SUM_W'(DEPTH))
                                                 : sum_m1[IDX_W-1:0];

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        op.kind    = OP_NOTE;
        op.status  = ST_OK;
        op.addr    = '0;
        op.len     = '0;
        op.value   = '0;
        case (command_e'(request.command))
            CMD_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    op.status = ST_OVER;
                end
                else
                begin
                    op.kind    = OP_WRITE;
                    op.addr    = ADDR_W'(front_dec);
                    op.value   = request.value;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    op.status = ST_OVER;
                end
                else
                begin
                    op.kind    = OP_WRITE;
                    op.addr    = ADDR_W'(back_pos);
                    op.value   = request.value;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (is_empty)
                begin
                    op.status = ST_UNDER;
                end
                else
                begin
                    op.kind    = OP_READ;
                    op.addr    = ADDR_W'(front_reg);
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (is_empty)
                begin
                    op.status = ST_UNDER;
                end
                else
                begin
                    op.kind    = OP_READ;
                    op.addr    = ADDR_W'(back_last);
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_DUMP:
            begin
                if (is_empty)
                begin
                    op.status = ST_EMPTY;
                end
                else
                begin
                    op.kind = OP_DUMP;
                    op.addr = ADDR_W'(front_reg);
                    op.len  = LEN_W'(count_reg);
                end
            end
            default:
            begin
                op.kind = OP_NOTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/dq_back.sv
// ----------------------------------------------------------------------------
// Double-ended queue back end
// Owns the entry memory, executes queued operations in order, walks the ring
// for a dump and forms result requests.
// ----------------------------------------------------------------------------
module dq_back #(
    parameter int DEPTH  = 16,
    parameter int RES_AW = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dq_pkg::op_t       op,
    input  logic              op_empty,
    output logic              op_pop,
    input  logic [RES_AW:0]   res_level,
    output logic              res_push,
    output dq_pkg::result_t   res_data
);
    import dq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RES_N = 1 << RES_AW;
    localparam int LVL_W = RES_AW + 2;

    logic signed [VALUE_W-1:0] mem_reg [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] left_next;
    logic             s2_valid_reg;
    logic             s2_valid_next;
    status_e          s2_status_reg;
    status_e          s2_status_next;
    logic             s2_last_reg;
    logic             s2_last_next;
    logic             s2_mem_reg;
    logic             s2_mem_next;

    logic             can_issue;
    logic [LVL_W-1:0] lvl_sum;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_addr;
    logic [IDX_W-1:0] op_idx;
    logic [IDX_W-1:0] op_idx_inc;
    logic [IDX_W-1:0] pos_inc;

    assign lvl_sum    = LVL_W'(res_level) + LVL_W'(s2_valid_reg);
    assign can_issue  = (lvl_sum < LVL_W'(RES_N));
    assign op_idx     = op.addr[IDX_W-1:0];
    assign op_idx_inc = (op_idx == IDX_W'(DEPTH - 1)) ? '0 : op_idx + 1'b1;
    assign pos_inc    = (pos_reg == IDX_W'(DEPTH - 1)) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        s2_valid_next  = 1'b0;
        s2_status_next = ST_OK;
        s2_last_next   = 1'b1;
        s2_mem_next    = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = busy_reg ? pos_reg : op_idx;
        op_pop         = 1'b0;
        if (can_issue)
        begin
            if (busy_reg)
            begin
                mem_re        = 1'b1;
                s2_valid_next = 1'b1;
                s2_mem_next   = 1'b1;
                s2_last_next  = (left_reg == CNT_W'(1));
                busy_next     = (left_reg != CNT_W'(1));
                left_next     = left_reg - 1'b1;
                pos_next      = pos_inc;
            end
            else if (!op_empty)
            begin
                op_pop         = 1'b1;
                s2_valid_next  = 1'b1;
                s2_status_next = op.status;
                case (op.kind)
                    OP_WRITE:
                    begin
                        mem_we = 1'b1;
                    end
                    OP_READ:
                    begin
                        mem_re      = 1'b1;
                        s2_mem_next = 1'b1;
                    end
                    OP_DUMP:
                    begin
                        mem_re       = 1'b1;
                        s2_mem_next  = 1'b1;
                        s2_last_next = (op.len[CNT_W-1:0] == CNT_W'(1));
                        busy_next    = (op.len[CNT_W-1:0] != CNT_W'(1));
                        left_next    = op.len[CNT_W-1:0] - 1'b1;
                        pos_next     = op_idx_inc;
                    end
                    default:
                    begin
                        s2_mem_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_push        = s2_valid_reg;
        res_data.status = s2_status_reg;
        res_data.data   = s2_mem_reg ? rd_data_reg : '0;
        res_data.last   = s2_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_addr] <= op.value;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem_reg[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            left_reg      <= '0;
            s2_valid_reg  <= 1'b0;
            s2_status_reg <= ST_OK;
            s2_last_reg   <= 1'b0;
            s2_mem_reg    <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            left_reg      <= left_next;
            s2_valid_reg  <= s2_valid_next;
            s2_status_reg <= s2_status_next;
            s2_last_reg   <= s2_last_next;
            s2_mem_reg    <= s2_mem_next;
        end
    end

endmodule

// File: rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit values in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// Push front, push back, pop front and pop back each give one result, and the
// block takes one such request per clock while results are popped at the same
// rate. A dump of N stored values gives N results, one per clock while the
// result queue has room, paced by the single read port of the entry memory;
// requests keep entering the two-entry operation queue meanwhile and full
// rises when it fills. A full queue drops a push with status overflow, an
// empty one answers a pop with underflow and a dump with status empty; the
// last result of every request carries last.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  dq_pkg::request_t  request,
    output logic              empty,
    input  logic              pop,
    output dq_pkg::result_t   result
);
    import dq_pkg::*;

    localparam int OP_AW  = 1;
    localparam int RES_AW = 2;

    op_t               front_op;
    op_t               queued_op;
    logic              op_full;
    logic              op_empty;
    logic              op_pop;
    logic              accept;
    logic              res_push;
    result_t           res_data;
    logic [RES_AW:0]   res_level;

    assign accept = push && !op_full;
    assign full   = op_full;

    dq_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .op      (front_op)
    );

    dq_fifo #(
        .AW     (OP_AW),
        .item_t (op_t)
    ) u_op_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_op),
        .full    (op_full),
        .rd_en   (op_pop),
        .rd_data (queued_op),
        .empty   (op_empty),
        .level   ()
    );

    dq_back #(
        .DEPTH  (DEPTH),
        .RES_AW (RES_AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (queued_op),
        .op_empty  (op_empty),
        .op_pop    (op_pop),
        .res_level (res_level),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    dq_fifo #(
        .AW     (RES_AW),
        .item_t (result_t)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty),
        .level   (res_level)
    );

endmodule

// File: rtl/core/dq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level assertions on the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input dq_pkg::result_t   result
);
    import dq_pkg::*;

    logic [7:0] open_reg;
    logic [7:0] open_next;
    logic       req_taken;
    logic       last_taken;

    assign req_taken  = push && !full;
    assign last_taken = pop && !empty && result.last;

    always_comb
    begin
        open_next = open_reg;
        if (req_taken && !last_taken)
        begin
            open_next = open_reg + 1'b1;
        end
        else if (last_taken && !req_taken)
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_no_result_without_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        (open_reg == '0) |-> empty
    ) else $error("result shown with no request outstanding");

    a_error_status_single: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && (result.status != ST_OK)) |-> (result.last && (result.data == '0))
    ) else $error("error status result not final or carries data");

    a_last_needs_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        last_taken |-> ((open_reg != '0) || req_taken)
    ) else $error("final result popped with no request outstanding");

    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result))
    ) else $error("waiting result changed before pop");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

// File: tb/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Directed table of requests covering empty, full and reserved commands,
// then about 500 random requests in fill and drain runs under four
// push/pop idle patterns; every result is checked against a shadow deque.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int DEPTH            = 16;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int DRAIN_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int SEND_IDLE [4]    = '{0, 77, 0, 19};
    localparam int POP_STALL [4]    = '{0, 0, 77, 19};

    localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] CMD_RESERVED_MID   = 3'd6;
    localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

    typedef struct {
        logic [2:0]          command;
        logic signed [31:0]  value;
        int                  reps;
        bit                  typed;
        logic [1:0]          status;
        logic signed [31:0]  data;
    } table_row_t;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    request_t request;
    logic     empty;
    logic     pop;
    result_t  result;

    logic signed [31:0] shadow_entries [DEPTH];
    int                 shadow_front;
    int                 shadow_count;
    result_t            pending_results [$];

    int send_idle_pct;
    int pop_stall_pct;
    int error_count;
    int requests_sent;
    int results_checked;
    int dump_count;
    int overflow_count;
    int underflow_count;

    double_ended_queue #(.DEPTH(DEPTH)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic table_row_t mk_row(input logic [2:0] command,
                                          input logic signed [31:0] value,
                                          input int reps, input bit typed,
                                          input logic [1:0] status,
                                          input logic signed [31:0] data);
        table_row_t r;
        r.command = command;
        r.value   = value;
        r.reps    = reps;
        r.typed   = typed;
        r.status  = status;
        r.data    = data;
        return r;
    endfunction

    function automatic void expect_result(input logic [1:0] status,
                                          input logic signed [31:0] data,
                                          input logic last);
        result_t r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void apply_to_shadow_deque(input request_t req);
        int pos;
        requests_sent++;
        case (req.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                begin
                    overflow_count++;
                    expect_result(ST_OVER, '0, 1'b1);
                end
                else
                begin
                    if (req.command == CMD_PUSH_FRONT)
                    begin
                        shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
                        pos = shadow_front;
                    end
                    else
                        pos = (shadow_front + shadow_count) % DEPTH;
                    shadow_entries[pos] = req.value;
                    shadow_count++;
                    expect_result(ST_OK, '0, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    underflow_count++;
                    expect_result(ST_UNDER, '0, 1'b1);
                end
                else if (req.command == CMD_POP_FRONT)
                begin
                    expect_result(ST_OK, shadow_entries[shadow_front], 1'b1);
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
                else
                begin
                    pos = (shadow_front + shadow_count - 1) % DEPTH;
                    expect_result(ST_OK, shadow_entries[pos], 1'b1);
                    shadow_count--;
                end
            end
            CMD_DUMP:
            begin
                dump_count++;
                if (shadow_count == 0)
                    expect_result(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < shadow_count; i++)
                        expect_result(ST_OK, shadow_entries[(shadow_front + i) % DEPTH],
                                      i == shadow_count - 1);
            end
            default:
                expect_result(ST_OK, '0, 1'b1);
        endcase
    endfunction

    task automatic send_request(input request_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        request <= req;
        do @(negedge clk); while (full);
        @(posedge clk);
    endtask

    // receiver: decide pop at the edge, sample the result at mid-cycle
    initial
    begin
        result_t want;
        pop <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            pop <= ($urandom_range(99) >= pop_stall_pct);
            @(negedge clk);
            if (pop && !empty)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: status %0d data %0d last %0b",
                             $time, result.status, result.data, result.last);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, result.status);
                    end
                    if (result.data !== want.data)
                    begin
                        error_count++;
                        $display("%0t: data mismatch: expected %0d, actual %0d",
                                 $time, want.data, result.data);
                    end
                    if (result.last !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, result.last);
                    end
                end
            end
            @(posedge clk);
        end
    end

    initial
    begin
        table_row_t directed_table [25];
        request_t   req;
        int         n;
        int         pick;
        int         wait_cycles;
        bit         filling;

        push          <= 1'b0;
        request       <= '0;
        rst_n         <= 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        shadow_front  = 0;
        shadow_count  = 0;
        foreach (shadow_entries[i]) shadow_entries[i] = '0;

        directed_table = '{
            mk_row(CMD_POP_FRONT,      32'sd0,            1,  1, ST_UNDER, 32'sd0),
            mk_row(CMD_POP_BACK,       32'sd0,            1,  1, ST_UNDER, 32'sd0),
            mk_row(CMD_DUMP,           32'sd0,            1,  1, ST_EMPTY, 32'sd0),
            mk_row(CMD_RESERVED_FIRST, -32'sd1,           1,  1, ST_OK,    32'sd0),
            mk_row(CMD_RESERVED_LAST,  32'sh7fff_ffff,    1,  1, ST_OK,    32'sd0),
            mk_row(CMD_PUSH_FRONT,     32'sh7fff_ffff,    1,  1, ST_OK,    32'sd0),
            mk_row(CMD_PUSH_BACK,      32'sh8000_0000,    1,  1, ST_OK,    32'sd0),
            mk_row(CMD_PUSH_FRONT,     -32'sd1,           1,  1, ST_OK,    32'sd0),
            mk_row(CMD_DUMP,           32'sd0,            1,  0, ST_OK,    32'sd0),
            mk_row(CMD_POP_BACK,       32'sd0,            1,  0, ST_OK,    32'sd0),
            mk_row(CMD_POP_FRONT,      32'sd0,            1,  0, ST_OK,    32'sd0),
            mk_row(CMD_POP_FRONT,      32'sd0,            1,  0, ST_OK,    32'sd0),
            mk_row(CMD_POP_BACK,       32'sd0,            1,  1, ST_UNDER, 32'sd0),
            mk_row(CMD_PUSH_BACK,      32'sh0000_0100,    DEPTH, 1, ST_OK, 32'sd0),
            mk_row(CMD_PUSH_FRONT,     32'sh1234_5678,    1,  1, ST_OVER,  32'sd0),
            mk_row(CMD_PUSH_BACK,      32'sh8765_4321,    1,  1, ST_OVER,  32'sd0),
            mk_row(CMD_DUMP,           32'sd0,            1,  0, ST_OK,    32'sd0),
            mk_row(CMD_POP_BACK,       32'sd0,            1,  0, ST_OK,    32'sd0),
            mk_row(CMD_PUSH_FRONT,     32'sh5555_5555,    1,  1, ST_OK,    32'sd0),
            mk_row(CMD_RESERVED_MID,   32'sh5555_5555,    1,  1, ST_OK,    32'sd0),
            mk_row(CMD_DUMP,           32'sd0,            1,  0, ST_OK,    32'sd0),
            mk_row(CMD_POP_FRONT,      32'sd0,            DEPTH, 0, ST_OK, 32'sd0),
            mk_row(CMD_DUMP,           32'sd0,            1,  1, ST_EMPTY, 32'sd0),
            mk_row(CMD_PUSH_BACK,      32'shaaaa_aaaa,    1,  1, ST_OK,    32'sd0),
            mk_row(CMD_POP_FRONT,      32'sd0,            1,  0, ST_OK,    32'sd0)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[r])
            for (int k = 0; k < directed_table[r].reps; k++)
            begin
                req.command = directed_table[r].command;
                req.value   = directed_table[r].value + k;
                send_request(req);
                n = pending_results.size();
                apply_to_shadow_deque(req);
                if (directed_table[r].typed)
                begin
                    while (pending_results.size() > n) void'(pending_results.pop_back());
                    expect_result(directed_table[r].status, directed_table[r].data, 1'b1);
                end
            end

        // random runs that alternate between filling and draining
        filling = 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = SEND_IDLE[p];
            pop_stall_pct = POP_STALL[p];
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if ($urandom_range(19) == 0) filling = !filling;
                pick = $urandom_range(99);
                if (pick < (filling ? 60 : 25))
                    req.command = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                else if (pick < (filling ? 82 : 72))
                    req.command = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
                else if (pick < 94)
                    req.command = CMD_DUMP;
                else
                    req.command = $urandom_range(CMD_RESERVED_LAST, CMD_RESERVED_FIRST);
                case ($urandom_range(15))
                    0:       req.value = 32'sh8000_0000;
                    1:       req.value = 32'sh7fff_ffff;
                    2:       req.value = 32'sd0;
                    3:       req.value = -32'sd1;
                    default: req.value = $urandom;
                endcase
                send_request(req);
                apply_to_shadow_deque(req);
            end
        end
        push <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            error_count += pending_results.size();
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end

        $display("Covered %0d requests (%0d dumps, %0d overflows, %0d underflows)",
                 requests_sent, dump_count, overflow_count, underflow_count);
        $display("and %0d results under four push/pop idle patterns, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/dq_pkg.sv
rtl/core/dq_fifo.sv
rtl/core/dq_front.sv
rtl/core/dq_back.sv
rtl/core/double_ended_queue.sv
rtl/core/dq_checker.sv
tb/tb_double_ended_queue.sv
